FILE: design/ac_dim_pkg.sv
package ac_dim_pkg;

   localparam int CHANNELS_MAX   = 6;
   localparam int CHANNELS_DEF   = 6;
   localparam int REVERT_DIV_DEF = 4;
   localparam int PHASE_STEP     = 150;
   localparam int RAMP_STEP      = 5;

   localparam int LEVEL_OFF_BELOW = 5;
   localparam int LEVEL_FULL      = 128;
   localparam int UNKNOWN_VALUE   = 8'hFF;
   localparam int REVERT_SCALE    = 5;
   localparam int DELAY_MAX       = 32767;

   localparam int CH_IDX_W   = 3;
   localparam int CD_W       = 11;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_TICK  = 2'd2;

   localparam logic KIND_REPLY  = 1'b0;
   localparam logic KIND_UPDATE = 1'b1;

   localparam logic [2:0] REG_NUM_CH  = 3'd0;
   localparam logic [2:0] REG_DEV_ID0 = 3'd1;
   localparam logic [2:0] REG_COORD   = 3'd7;

   typedef enum logic [1:0] {
      OP_WRITE,
      OP_READ,
      OP_UNKNOWN,
      OP_TICK
   } op_type;

   typedef enum logic [1:0] {
      DRV_OFF  = 2'd0,
      DRV_FULL = 2'd1,
      DRV_DIM  = 2'd2
   } drive_type;

   typedef enum logic {
      BK_IDLE,
      BK_TICK
   } back_state_type;

   typedef struct packed {
      op_type                op;
      logic [CH_IDX_W-1:0]   chan;
      logic [15:0]           device;
      logic [7:0]            level;
      logic [7:0]            secs;
      logic [15:0]           dest;
   } cmd_type;

   typedef struct packed {
      logic [CH_IDX_W-1:0] active;
   } cfg_status_type;

   typedef struct packed {
      logic                kind;
      logic                last;
      logic [14:0]         fire_delay;
      drive_type           drive;
      logic [7:0]          level;
      logic [2:0]          channel;
      logic [7:0]          value;
      logic [15:0]         device;
      logic [15:0]         destination;
   } rsp_type;

endpackage

FILE: design/ac_dim_front.sv
module ac_dim_front import ac_dim_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   // device_address[15:0], new_level[23:16], revert_seconds[31:24],
   // requester_address[47:32]
   input  logic [47:0]    req_tdata,
   // mode[1:0]
   input  logic [1:0]     req_tuser,
   input  logic           csr_valid,
   output logic           csr_ready,
   input  logic [2:0]     csr_index,
   input  logic [15:0]    csr_data,
   input  logic           q_full,
   output logic           q_push,
   output cmd_type        q_cmd,
   output cfg_status_type status
);

   logic [2:0]  num_ch_ff;
   logic [15:0] dev_id_ff [CHANNELS];
   logic [15:0] coord_ff;

   logic [CH_IDX_W-1:0] active;
   logic                hit;
   logic [CH_IDX_W-1:0] found;
   logic [15:0]         dev;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ch_ff <= '0;
         coord_ff  <= '0;
         for (int i = 0; i < CHANNELS; i++) dev_id_ff[i] <= '0;
      end else if (csr_valid) begin
         if (csr_index == REG_NUM_CH) num_ch_ff <= csr_data[2:0];
         if (csr_index == REG_COORD) coord_ff <= csr_data;
         for (int i = 0; i < CHANNELS; i++) begin
            if (csr_index == REG_DEV_ID0 + 3'(i)) dev_id_ff[i] <= csr_data;
         end
      end
   end

   assign active = (32'(num_ch_ff) > CHANNELS) ? CH_IDX_W'(CHANNELS) : num_ch_ff;
   assign status.active = active;
   assign dev = req_tdata[15:0];

   // lowest matching channel wins
   always_comb begin
      hit   = 1'b0;
      found = '0;
      for (int i = CHANNELS - 1; i >= 0; i--) begin
         if (CH_IDX_W'(i) < active && dev_id_ff[i] == dev) begin
            hit   = 1'b1;
            found = CH_IDX_W'(i);
         end
      end
   end

   assign req_tready = !q_full;

   always_comb begin
      q_cmd.chan   = found;
      q_cmd.device = dev;
      q_cmd.level  = req_tdata[23:16];
      q_cmd.secs   = req_tdata[31:24];
      q_cmd.dest   = req_tdata[47:32];
      q_cmd.op     = OP_UNKNOWN;
      q_push       = req_tvalid && req_tready;
      unique case (req_tuser)
         MODE_WRITE: begin
            if (hit) begin
               q_cmd.op   = OP_WRITE;
               q_cmd.dest = coord_ff;
            end
         end
         MODE_READ: begin
            if (hit) q_cmd.op = OP_READ;
         end
         MODE_TICK: q_cmd.op = OP_TICK;
         default: q_push = 1'b0;   // drop unused mode
      endcase
   end

endmodule

FILE: design/ac_dim_queue.sv
module ac_dim_queue import ac_dim_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cmd_type         slot_ff [QUEUE_DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full       = (count_ff == CW'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

FILE: design/ac_dim_back.sv
module ac_dim_back import ac_dim_pkg::*; #(
   parameter int CHANNELS      = CHANNELS_DEF,
   parameter int REVERT_DIVIDE = REVERT_DIV_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           cmd_valid,
   input  cmd_type        cmd,
   output logic           cmd_pop,
   input  cfg_status_type status,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [71:0]    rsp_tdata,
   output logic           rsp_tuser,
   output logic           rsp_tlast
);

   localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PW = (REVERT_DIVIDE > 1) ? $clog2(REVERT_DIVIDE) : 1;

   back_state_type      state_ff, state_in;
   logic [CH_IDX_W-1:0] idx_ff, idx_in;
   logic [CHANNELS-1:0] mask_ff, mask_in, mask_now;
   logic [PW-1:0]       phase_ff, phase_in;

   logic [7:0]      cur_ff   [CHANNELS];
   logic [7:0]      cur_in   [CHANNELS];
   logic [7:0]      tgt_ff   [CHANNELS];
   logic [7:0]      tgt_in   [CHANNELS];
   logic [7:0]      prior_ff [CHANNELS];
   logic [7:0]      prior_in [CHANNELS];
   logic [CD_W-1:0] cd_ff    [CHANNELS];
   logic [CD_W-1:0] cd_in    [CHANNELS];

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [CW-1:0] addr;
   logic [7:0]    cur_rd, tgt_rd;
   logic [CD_W-1:0] cd_rd;
   logic          out_free;
   logic          later;
   logic [7:0]    diff;
   logic [8:0]    nx;
   logic [7:0]    span;
   logic [16:0]   prod;
   logic [7:0]    map_level;
   drive_type     map_drive;
   logic [14:0]   map_delay;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign addr     = (state_ff == BK_TICK) ? idx_ff[CW-1:0] : cmd.chan[CW-1:0];
   assign cur_rd   = cur_ff[addr];
   assign tgt_rd   = tgt_ff[addr];
   assign cd_rd    = cd_ff[addr];

   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         mask_now[i] = (CH_IDX_W'(i) < status.active) && (tgt_ff[i] != cur_ff[i]);
      end
   end

   // any update still to come in this walk
   always_comb begin
      later = 1'b0;
      for (int j = 0; j < CHANNELS; j++) begin
         if (CH_IDX_W'(j) > idx_ff && mask_ff[j]) later = 1'b1;
      end
   end

   // ramp one step toward target and map to drive
   always_comb begin
      if (tgt_rd > cur_rd) begin
         diff = tgt_rd - cur_rd;
         nx   = (32'(diff) > RAMP_STEP) ? 9'(cur_rd) + 9'(RAMP_STEP) : 9'(tgt_rd);
      end else begin
         diff = cur_rd - tgt_rd;
         nx   = (32'(diff) > RAMP_STEP) ? 9'(cur_rd) - 9'(RAMP_STEP) : 9'(tgt_rd);
      end
      span = 8'(LEVEL_FULL) - nx[7:0];
      prod = 17'(PHASE_STEP) * 17'(span);
      priority if (32'(nx) < LEVEL_OFF_BELOW) begin
         map_level = '0;
         map_drive = DRV_OFF;
         map_delay = '0;
      end else if (32'(nx) >= LEVEL_FULL) begin
         map_level = 8'(LEVEL_FULL);
         map_drive = DRV_FULL;
         map_delay = '0;
      end else begin
         map_level = nx[7:0];
         map_drive = DRV_DIM;
         map_delay = (32'(prod) > DELAY_MAX) ? 15'(DELAY_MAX) : prod[14:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      mask_in      = mask_ff;
      phase_in     = phase_ff;
      cur_in       = cur_ff;
      tgt_in       = tgt_ff;
      prior_in     = prior_ff;
      cd_in        = cd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      cmd_pop      = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               if (cmd.op == OP_TICK) begin
                  cmd_pop  = 1'b1;
                  idx_in   = '0;
                  mask_in  = mask_now;
                  state_in = BK_TICK;
               end else if (out_free) begin
                  cmd_pop            = 1'b1;
                  rsp_valid_in       = 1'b1;
                  rsp_in             = '0;
                  rsp_in.kind        = KIND_REPLY;
                  rsp_in.last        = 1'b1;
                  rsp_in.destination = cmd.dest;
                  rsp_in.device      = cmd.device;
                  unique case (cmd.op)
                     OP_WRITE: begin
                        rsp_in.value   = cmd.level;
                        prior_in[addr] = tgt_rd;
                        tgt_in[addr]   = cmd.level;
                        cd_in[addr]    = CD_W'(cmd.secs) * CD_W'(REVERT_SCALE);
                     end
                     OP_READ:    rsp_in.value = tgt_rd;
                     default:    rsp_in.value = 8'(UNKNOWN_VALUE);
                  endcase
               end
            end
         end
         BK_TICK: begin
            if (idx_ff >= status.active) begin
               phase_in = (32'(phase_ff) + 1 >= REVERT_DIVIDE) ? '0 : phase_ff + 1'b1;
               state_in = BK_IDLE;
            end else if (!mask_ff[addr] || out_free) begin
               if (mask_ff[addr]) begin
                  cur_in[addr]      = map_level;
                  rsp_valid_in      = 1'b1;
                  rsp_in            = '0;
                  rsp_in.kind       = KIND_UPDATE;
                  rsp_in.channel    = 3'(idx_ff);
                  rsp_in.level      = map_level;
                  rsp_in.drive      = map_drive;
                  rsp_in.fire_delay = map_delay;
                  rsp_in.last       = !later;
               end
               if (phase_ff == '0) begin
                  if (cd_rd > CD_W'(1)) begin
                     cd_in[addr] = cd_rd - 1'b1;
                  end else if (cd_rd == CD_W'(1)) begin
                     cd_in[addr]  = '0;
                     tgt_in[addr] = prior_ff[addr];
                  end
               end
               idx_in = idx_ff + 1'b1;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         idx_ff       <= '0;
         mask_ff      <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            cur_ff[i]   <= '0;
            tgt_ff[i]   <= '0;
            prior_ff[i] <= '0;
            cd_ff[i]    <= '0;
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         mask_ff      <= mask_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_ff       <= cur_in;
         tgt_ff       <= tgt_in;
         prior_ff     <= prior_in;
         cd_ff        <= cd_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {4'b0, rsp_ff.fire_delay, rsp_ff.drive, rsp_ff.level,
                        rsp_ff.channel, rsp_ff.value, rsp_ff.device, rsp_ff.destination};

endmodule

FILE: design/ac_dimmer_channel_controller_core.sv
// Command request: the reply passes through the queue, then the output register;
// commands sustain one per cycle while the output is free and no tick walk is running.
// Tick request: the first update passes through the queue, the tick state and the output register;
// the walk visits one channel per cycle while the output register can take an update.
// The walk stalls only while an update waits in the full output register; two requests queue.
// Synchronous active-high reset clears all channel state, tick phase and config registers.
module ac_dimmer_channel_controller_core import ac_dim_pkg::*; #(
   parameter int CHANNELS      = CHANNELS_DEF,
   parameter int REVERT_DIVIDE = REVERT_DIV_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // device_address[15:0], new_level[23:16], revert_seconds[31:24],
   // requester_address[47:32]
   input  logic [47:0] req_tdata,
   // mode[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // destination[15:0], reply_device[31:16], reply_value[39:32], channel[42:40],
   // level[50:43], drive[52:51], fire_delay[67:53], zero fill[71:68]
   output logic [71:0] rsp_tdata,
   // kind[0]
   output logic        rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic           q_full, q_push, q_pop, q_valid;
   cmd_type        q_cmd, head_cmd;
   cfg_status_type status;

   ac_dim_front #(.CHANNELS(CHANNELS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_cmd),
      .status     (status)
   );

   ac_dim_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (head_cmd)
   );

   ac_dim_back #(.CHANNELS(CHANNELS), .REVERT_DIVIDE(REVERT_DIVIDE)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (q_valid),
      .cmd        (head_cmd),
      .cmd_pop    (q_pop),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
